// ===== sv/cte_pkg.sv =====
`timescale 1ns / 1ps

package cte_pkg;

    localparam int DEF_MAX_ROWS = 16;
    localparam int DEF_MAX_COLS = 16;

    localparam int ENTRY_W = 40;
    localparam int SUM_W   = 48;
    localparam int PROP_W  = 16;
    localparam int SIZE_W  = 5;

    localparam logic [3:0] OP_CLEAR    = 4'd0;
    localparam logic [3:0] OP_SET      = 4'd1;
    localparam logic [3:0] OP_ADD      = 4'd2;
    localparam logic [3:0] OP_READ     = 4'd3;
    localparam logic [3:0] OP_ROW_SUM  = 4'd4;
    localparam logic [3:0] OP_COL_SUM  = 4'd5;
    localparam logic [3:0] OP_TOTAL    = 4'd6;
    localparam logic [3:0] OP_MAX      = 4'd7;
    localparam logic [3:0] OP_MIN      = 4'd8;
    localparam logic [3:0] OP_P_CELL   = 4'd9;
    localparam logic [3:0] OP_P_ROW    = 4'd10;
    localparam logic [3:0] OP_P_COL    = 4'd11;
    localparam logic [3:0] OP_P_CELL_R = 4'd12;
    localparam logic [3:0] OP_P_CELL_C = 4'd13;
    // Spare codes: they do nothing and return an all-zero result.
    localparam logic [3:0] OP_SPARE_E  = 4'd14;
    localparam logic [3:0] OP_SPARE_F  = 4'd15;

    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    typedef struct packed {
        logic [3:0]         opcode;
        logic [3:0]         table_row;
        logic [3:0]         table_col;
        logic [ENTRY_W-1:0] operand_value;
    } t_in;

    typedef struct packed {
        logic [SUM_W-1:0] result_value;
        logic             range_error;
        logic             undefined_ratio;
    } t_out;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_RD,
        S_SCAN,
        S_DRAIN,
        S_EVAL,
        S_DIV,
        S_FIN
    } t_state;

endpackage

// ===== sv/contingency_table_engine.sv =====
`timescale 1ns / 1ps
// One item is in work at a time; the table scan and the bit-serial divider set the rate.
// Reset (synchronous, active low) starts a clearing pass of the whole table, during
// which no item is taken; a configuration write starts the same pass.
module contingency_table_engine #(
    parameter int MAX_ROWS = cte_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = cte_pkg::DEF_MAX_COLS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  cte_pkg::t_in              i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output cte_pkg::t_out             o_out,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [cte_pkg::SIZE_W-1:0] i_cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int EW    = cte_pkg::ENTRY_W;
    localparam int SW    = cte_pkg::SUM_W;
    localparam int PW    = cte_pkg::PROP_W;
    localparam logic [SW-1:0] SUM_MAX = {SW{1'b1}};

    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rdata;

    cte_pkg::t_state r_state, n_state;

    logic [cte_pkg::SIZE_W-1:0] r_num_rows, r_num_cols;
    logic [3:0]    r_op, r_row, r_col;
    logic [AW-1:0] r_addr, r_cnt;
    logic [EW-1:0] r_val;
    logic          r_reply;
    logic [RW-1:0] r_sr;
    logic [CW-1:0] r_sc;
    logic          r_tag_v, r_tag_first, r_tag_row, r_tag_col;
    logic [SW-1:0] r_total, r_rsum, r_csum;
    logic [EW-1:0] r_cell, r_max, r_min;
    logic [SW:0]   r_rem;
    logic [SW-1:0] r_den;
    logic [PW-1:0] r_q;
    logic [3:0]    r_step;
    cte_pkg::t_out r_res;
    logic          r_out_valid;
    cte_pkg::t_out r_out;

    logic          accept, need_r, need_c, bad;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr, in_addr, scan_addr;
    logic [EW-1:0] mem_wdata;
    logic [EW:0]   add_sum;
    logic          scan_last, out_free;
    logic [SW-1:0] ev_num, ev_den;
    logic          ev_ratio;
    logic [SW:0]   rem2;

    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [SW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SW] ? SUM_MAX : s[SW-1:0];
    endfunction

    function automatic logic [cte_pkg::SIZE_W-1:0] clamp(input logic [cte_pkg::SIZE_W-1:0] v,
                                                        input int hi);
        if (int'(v) < 2) return cte_pkg::SIZE_W'(2);
        if (int'(v) > hi) return cte_pkg::SIZE_W'(hi);
        return v;
    endfunction

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign need_r = (i_in.opcode >= cte_pkg::OP_SET && i_in.opcode <= cte_pkg::OP_ROW_SUM)
                 || i_in.opcode == cte_pkg::OP_P_CELL || i_in.opcode == cte_pkg::OP_P_ROW
                 || i_in.opcode == cte_pkg::OP_P_CELL_R || i_in.opcode == cte_pkg::OP_P_CELL_C;
    assign need_c = (i_in.opcode >= cte_pkg::OP_SET && i_in.opcode <= cte_pkg::OP_READ)
                 || i_in.opcode == cte_pkg::OP_COL_SUM || i_in.opcode == cte_pkg::OP_P_CELL
                 || (i_in.opcode >= cte_pkg::OP_P_COL && i_in.opcode <= cte_pkg::OP_P_CELL_C);
    assign bad = (need_r && {1'b0, i_in.table_row} >= r_num_rows)
              || (need_c && {1'b0, i_in.table_col} >= r_num_cols);
    assign in_addr   = AW'(int'(i_in.table_row) * MAX_COLS + int'(i_in.table_col));
    assign scan_addr = AW'(int'(r_sr) * MAX_COLS + int'(r_sc));
    assign scan_last = (int'(r_sr) + 1 == int'(r_num_rows)) && (int'(r_sc) + 1 == int'(r_num_cols));
    assign add_sum   = {1'b0, r_rdata} + {1'b0, r_val};
    assign rem2      = {r_rem[SW-1:0], 1'b0};

    // Numerator and denominator of a proportion, from the scan accumulators.
    always_comb begin
        ev_num   = '0;
        ev_den   = '0;
        ev_ratio = 1'b1;
        case (r_op)
            cte_pkg::OP_P_CELL:   begin ev_num = SW'(r_cell); ev_den = r_total; end
            cte_pkg::OP_P_ROW:    begin ev_num = r_rsum;      ev_den = r_total; end
            cte_pkg::OP_P_COL:    begin ev_num = r_csum;      ev_den = r_total; end
            cte_pkg::OP_P_CELL_R: begin ev_num = SW'(r_cell); ev_den = r_rsum;  end
            cte_pkg::OP_P_CELL_C: begin ev_num = SW'(r_cell); ev_den = r_csum;  end
            default:              ev_ratio = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            cte_pkg::S_CLR: begin
                if (r_cnt == AW'(DEPTH - 1))
                    n_state = r_reply ? cte_pkg::S_FIN : cte_pkg::S_IDLE;
            end
            cte_pkg::S_IDLE: begin
                if (accept) begin
                    if (bad) n_state = cte_pkg::S_FIN;
                    else begin
                        case (i_in.opcode)
                            cte_pkg::OP_CLEAR: n_state = cte_pkg::S_CLR;
                            cte_pkg::OP_ADD,
                            cte_pkg::OP_READ:  n_state = cte_pkg::S_RD;
                            cte_pkg::OP_ROW_SUM, cte_pkg::OP_COL_SUM, cte_pkg::OP_TOTAL,
                            cte_pkg::OP_MAX, cte_pkg::OP_MIN, cte_pkg::OP_P_CELL,
                            cte_pkg::OP_P_ROW, cte_pkg::OP_P_COL, cte_pkg::OP_P_CELL_R,
                            cte_pkg::OP_P_CELL_C: n_state = cte_pkg::S_SCAN;
                            default:           n_state = cte_pkg::S_FIN;
                        endcase
                    end
                end
            end
            cte_pkg::S_RD:    n_state = cte_pkg::S_FIN;
            cte_pkg::S_SCAN:  if (scan_last) n_state = cte_pkg::S_DRAIN;
            cte_pkg::S_DRAIN: n_state = cte_pkg::S_EVAL;
            cte_pkg::S_EVAL: begin
                n_state = (ev_ratio && ev_den != '0 && ev_num < ev_den) ? cte_pkg::S_DIV
                                                                         : cte_pkg::S_FIN;
            end
            cte_pkg::S_DIV:   if (r_step == 4'd0) n_state = cte_pkg::S_FIN;
            cte_pkg::S_FIN:   if (out_free) n_state = cte_pkg::S_IDLE;
            default: n_state = cte_pkg::S_IDLE;
        endcase
        if (i_cfg_we) n_state = cte_pkg::S_CLR;
    end

    always_comb begin
        o_in_ready = (r_state == cte_pkg::S_IDLE) && !i_cfg_we;
        mem_we     = 1'b0;
        mem_waddr  = r_addr;
        mem_wdata  = '0;
        mem_raddr  = scan_addr;
        case (r_state)
            cte_pkg::S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
            end
            cte_pkg::S_IDLE: begin
                mem_raddr = in_addr;
                if (accept && !bad && i_in.opcode == cte_pkg::OP_SET) begin
                    mem_we    = 1'b1;
                    mem_waddr = in_addr;
                    mem_wdata = i_in.operand_value;
                end
            end
            cte_pkg::S_RD: begin
                if (r_op == cte_pkg::OP_ADD) begin
                    mem_we    = 1'b1;
                    mem_wdata = add_sum[EW] ? {EW{1'b1}} : add_sum[EW-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cte_pkg::S_CLR;
            r_cnt       <= '0;
            r_reply     <= 1'b0;
            r_num_rows  <= cte_pkg::SIZE_W'(2);
            r_num_cols  <= cte_pkg::SIZE_W'(2);
            r_out_valid <= 1'b0;
            r_tag_v     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == cte_pkg::REG_NUM_ROWS) r_num_rows <= clamp(i_cfg_data, MAX_ROWS);
                else                                    r_num_cols <= clamp(i_cfg_data, MAX_COLS);
                r_cnt   <= '0;
                r_reply <= 1'b0;
            end else if (r_state == cte_pkg::S_CLR) begin
                r_cnt <= r_cnt + AW'(1);
            end else if (accept) begin
                r_cnt   <= '0;
                r_reply <= 1'b1;
            end
            r_tag_v <= (r_state == cte_pkg::S_SCAN);
            if (r_state == cte_pkg::S_FIN && out_free) r_out_valid <= 1'b1;
            else if (i_out_ready)                      r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_in.opcode;
            r_row   <= i_in.table_row;
            r_col   <= i_in.table_col;
            r_addr  <= in_addr;
            r_val   <= i_in.operand_value;
            r_sr    <= '0;
            r_sc    <= '0;
            r_total <= '0;
            r_rsum  <= '0;
            r_csum  <= '0;
            r_cell  <= '0;
            r_res   <= '{result_value: '0, range_error: bad, undefined_ratio: 1'b0};
        end
        if (r_state == cte_pkg::S_SCAN) begin
            if (int'(r_sc) + 1 == int'(r_num_cols)) begin
                r_sc <= '0;
                r_sr <= r_sr + RW'(1);
            end else begin
                r_sc <= r_sc + CW'(1);
            end
        end
        // Tags are registered from the scan address, so they line up with the registered read data.
        r_tag_first <= (r_sr == '0) && (r_sc == '0);
        r_tag_row   <= (int'(r_sr) == int'(r_row));
        r_tag_col   <= (int'(r_sc) == int'(r_col));
        if (r_tag_v) begin
            r_total <= sat_add(r_total, SW'(r_rdata));
            if (r_tag_row) r_rsum <= sat_add(r_rsum, SW'(r_rdata));
            if (r_tag_col) r_csum <= sat_add(r_csum, SW'(r_rdata));
            if (r_tag_row && r_tag_col) r_cell <= r_rdata;
            if (r_tag_first || r_rdata > r_max) r_max <= r_rdata;
            if (r_tag_first || r_rdata < r_min) r_min <= r_rdata;
        end
        if (r_state == cte_pkg::S_RD && r_op == cte_pkg::OP_READ)
            r_res.result_value <= SW'(r_rdata);
        if (r_state == cte_pkg::S_EVAL) begin
            case (r_op)
                cte_pkg::OP_ROW_SUM: r_res.result_value <= r_rsum;
                cte_pkg::OP_COL_SUM: r_res.result_value <= r_csum;
                cte_pkg::OP_TOTAL:   r_res.result_value <= r_total;
                cte_pkg::OP_MAX:     r_res.result_value <= SW'(r_max);
                cte_pkg::OP_MIN:     r_res.result_value <= SW'(r_min);
                default: begin
                    if (ev_den == '0) r_res.undefined_ratio <= 1'b1;
                    else if (ev_num >= ev_den) r_res.result_value <= SW'({PW{1'b1}});
                end
            endcase
            r_rem  <= {1'b0, ev_num};
            r_den  <= ev_den;
            r_step <= 4'(PW - 1);
        end
        if (r_state == cte_pkg::S_DIV) begin
            if (rem2 >= {1'b0, r_den}) begin
                r_rem <= rem2 - {1'b0, r_den};
                r_q   <= {r_q[PW-2:0], 1'b1};
            end else begin
                r_rem <= rem2;
                r_q   <= {r_q[PW-2:0], 1'b0};
            end
            r_step <= r_step - 4'd1;
            if (r_step == 4'd0) r_res.result_value <= SW'({r_q[PW-2:0], rem2 >= {1'b0, r_den}});
        end
        if (r_state == cte_pkg::S_FIN && out_free) r_out <= r_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== sv/cte_checker.sv =====
`timescale 1ns / 1ps
module cte_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input cte_pkg::t_out o_out
);

    // A result waiting for transfer stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed before transfer");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.range_error |-> o_out.result_value == '0 && !o_out.undefined_ratio)
        else $error("range error with nonzero result");

    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.undefined_ratio |-> o_out.result_value == '0)
        else $error("undefined ratio with nonzero result");

    // The clearing pass after reset keeps the input closed.
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("block open right after reset");

endmodule

bind contingency_table_engine cte_checker u_cte_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
